/* sv/ordered_retire_reorder_window_defines.svh */
// Assertion macros for the in-order retire window.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ORDERED_RETIRE_REORDER_WINDOW_DEFINES_SVH
`define ORDERED_RETIRE_REORDER_WINDOW_DEFINES_SVH

// Same-cycle implication, masked during reset
`define ORW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define ORW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/orw_pkg.sv */
// Shared types and constants of the in-order retire window.
// No dependencies; imported by every module of the block.
package orw_pkg;

    localparam int WINDOW_DEF   = 64;
    localparam int TAG_BITS_DEF = 32;

    localparam int HEIGHT_W = 31;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int TAG_W    = 32;
    localparam int LIMIT_W  = 7;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STALE     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TOO_FAR   = 3'd6;

    // Register index, taken from paddr[2]
    localparam logic REG_START_HEIGHT = 1'b0;
    localparam logic REG_MAX_AHEAD    = 1'b1;

    typedef struct packed {
        logic capture;      // latch the incoming item
        logic commit;       // apply the evaluated item (insert if allowed)
        logic single_load;  // load the single status result
        logic scan_start;   // arm the run scan at next height
        logic scan_step;    // test one slot of the run
        logic rd_issue;     // read the tag store
        logic emit;         // release one item to the output register
    } orw_cmd_t;

    typedef struct packed {
        logic run;          // insertion at next height: a run follows
        logic out_free;     // output register can take a result
        logic scan_done;    // run length is final after this step
        logic emit_last;    // item being released ends the run
    } orw_sts_t;

endpackage

/* sv/orw_if.sv */
// Stream interfaces of the in-order retire window: item in, result out.
// Depends on orw_pkg for field widths.
interface orw_in_if;
    import orw_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic signed [31:0]  in_height;
    logic [TAG_W-1:0]    in_tag;

    modport source (output valid, output mode, output in_height, output in_tag, input ready);
    modport sink   (input valid, input mode, input in_height, input in_tag, output ready);
endinterface

interface orw_out_if;
    import orw_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  rel_count;
    logic                has_item;
    logic [HEIGHT_W-1:0] out_height;
    logic [TAG_W-1:0]    out_tag;
    logic                last;

    modport source (output valid, output status, output rel_count, output has_item,
                    output out_height, output out_tag, output last, input ready);
    modport sink   (input valid, input status, input rel_count, input has_item,
                    input out_height, input out_tag, input last, output ready);
endinterface

/* sv/orw_ctrl.sv */
// Sequencer of the in-order retire window: accept, evaluate, scan, release.
// Depends on orw_pkg for the command and status structs.
module orw_ctrl
    import orw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output orw_cmd_t cmd,
    input  orw_sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PRIME = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.run)
                begin
                    cmd.commit     = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (sts.out_free)
                begin
                    cmd.commit      = 1'b1;
                    cmd.single_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                // fetch the first tag of the run
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.rd_issue = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/orw_dp.sv */
// Datapath of the in-order retire window: item evaluation, slot valid bits,
// tag store, run scan and the output register. Depends on orw_pkg.
module orw_dp
    import orw_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  orw_cmd_t            cmd,
    output orw_sts_t            sts,
    input  logic                in_mode,
    input  logic [31:0]         in_height,
    input  logic [TAG_W-1:0]    in_tag,
    input  logic                start_wr,
    input  logic [HEIGHT_W-1:0] start_value,
    input  logic [LIMIT_W-1:0]  max_ahead,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  rel_count,
    output logic                has_item,
    output logic [HEIGHT_W-1:0] out_height,
    output logic [TAG_W-1:0]    out_tag,
    output logic                last
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    // Captured item
    logic                mode_reg;
    logic [31:0]         height_reg;
    logic [STORE_W-1:0]  tag_reg;

    // Window state; slots map to heights relative to next_slot_reg
    logic [HEIGHT_W-1:0] next_height_reg;
    logic [SLOT_W-1:0]   next_slot_reg;
    logic [WINDOW-1:0]   slot_valid_reg;
    logic [STORE_W-1:0]  tag_mem [WINDOW];
    logic [STORE_W-1:0]  rd_data_reg;

    // Run scan and release
    logic [SLOT_W-1:0]   scan_slot_reg;
    logic [HEIGHT_W-1:0] scan_height_reg;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic [CNT_W-1:0]    emit_cnt_reg;

    // Output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  rel_count_reg;
    logic                has_item_reg;
    logic [HEIGHT_W-1:0] out_height_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic                last_reg;

    logic                negative;
    logic                stale;
    logic [HEIGHT_W-1:0] offset;
    logic [CNT_W-1:0]    limit;
    logic                beyond_limit;
    logic                beyond_window;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   ins_slot;
    logic                duplicate;
    logic                insert_ok;
    logic [STATUS_W-1:0] eval_status;
    logic                scan_hit;
    logic [SLOT_W-1:0]   next_slot_next;
    logic [SLOT_W-1:0]   rd_addr;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(WINDOW - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    // Evaluate the captured item against the window
    always_comb
    begin
        negative      = height_reg[31];
        stale         = height_reg[HEIGHT_W-1:0] < next_height_reg;
        offset        = height_reg[HEIGHT_W-1:0] - next_height_reg;
        if ((max_ahead == '0) || (32'(max_ahead) > 32'(WINDOW)))
        begin
            limit = CNT_W'(WINDOW);
        end
        else
        begin
            limit = CNT_W'(max_ahead);
        end
        beyond_limit  = offset >= HEIGHT_W'(limit);
        beyond_window = offset >= HEIGHT_W'(WINDOW);
        slot_sum      = {1'b0, next_slot_reg} + (SLOT_W + 1)'(offset[SLOT_W-1:0]);
        if (slot_sum >= (SLOT_W + 1)'(WINDOW))
        begin
            ins_slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW));
        end
        else
        begin
            ins_slot = slot_sum[SLOT_W-1:0];
        end
        duplicate = slot_valid_reg[ins_slot];
        insert_ok = 1'b0;
        if (negative)
        begin
            eval_status = ST_INVALID;
        end
        else if (stale)
        begin
            eval_status = ST_STALE;
        end
        else if (!mode_reg)
        begin
            eval_status = beyond_limit ? ST_TOO_FAR : ST_ACCEPTED;
        end
        else if (beyond_window)
        begin
            eval_status = ST_TOO_FAR;
        end
        else if (duplicate)
        begin
            eval_status = ST_DUPLICATE;
        end
        else
        begin
            eval_status = ST_QUEUED;
            insert_ok   = 1'b1;
        end
    end

    assign scan_hit       = slot_valid_reg[scan_slot_reg];
    assign next_slot_next = slot_inc(next_slot_reg);
    assign rd_addr        = cmd.emit ? next_slot_next : next_slot_reg;

    always_comb
    begin
        sts.run       = insert_ok && (offset == '0);
        sts.out_free  = !out_valid_reg || out_ready;
        sts.scan_done = !scan_hit || (scan_height_reg == HEIGHT_MAX)
                        || (scan_cnt_reg == CNT_W'(WINDOW - 1));
        sts.emit_last = (emit_cnt_reg == scan_cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= in_mode;
            height_reg <= in_height;
            tag_reg    <= in_tag[STORE_W-1:0];
        end
    end

    // Tag store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && insert_ok)
        begin
            tag_mem[ins_slot] <= tag_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_height_reg <= '0;
            next_slot_reg   <= '0;
            slot_valid_reg  <= '0;
            scan_slot_reg   <= '0;
            scan_height_reg <= '0;
            scan_cnt_reg    <= '0;
            emit_cnt_reg    <= '0;
        end
        else if (start_wr)
        begin
            // reload the window: every slot drops
            next_height_reg <= start_value;
            next_slot_reg   <= '0;
            slot_valid_reg  <= '0;
        end
        else
        begin
            if (cmd.commit && insert_ok)
            begin
                slot_valid_reg[ins_slot] <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                scan_slot_reg   <= next_slot_reg;
                scan_height_reg <= next_height_reg;
                scan_cnt_reg    <= '0;
                emit_cnt_reg    <= '0;
            end
            else if (cmd.scan_step && scan_hit)
            begin
                scan_slot_reg   <= slot_inc(scan_slot_reg);
                scan_height_reg <= scan_height_reg + 1'b1;
                scan_cnt_reg    <= scan_cnt_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                slot_valid_reg[next_slot_reg] <= 1'b0;
                emit_cnt_reg                  <= emit_cnt_reg + 1'b1;
                // hold at the top height
                if (next_height_reg != HEIGHT_MAX)
                begin
                    next_height_reg <= next_height_reg + 1'b1;
                    next_slot_reg   <= next_slot_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.single_load || cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.single_load)
        begin
            status_reg     <= eval_status;
            rel_count_reg  <= '0;
            has_item_reg   <= 1'b0;
            out_height_reg <= '0;
            out_tag_reg    <= '0;
            last_reg       <= 1'b1;
        end
        else if (cmd.emit)
        begin
            status_reg     <= ST_READY;
            rel_count_reg  <= COUNT_W'(scan_cnt_reg);
            has_item_reg   <= 1'b1;
            out_height_reg <= next_height_reg;
            out_tag_reg    <= TAG_W'(rd_data_reg);
            last_reg       <= sts.emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign rel_count  = rel_count_reg;
    assign has_item   = has_item_reg;
    assign out_height = out_height_reg;
    assign out_tag    = out_tag_reg;
    assign last       = last_reg;

endmodule

/* sv/ordered_retire_reorder_window.sv */
// Top level of the in-order retire window: APB registers, sequencer, datapath.
// Depends on orw_pkg, orw_if, orw_ctrl, orw_dp and the assertion macro header.
//
// Items are taken one at a time. An item that releases nothing (an admission
// check, a rejection or a parked insertion) is captured and evaluated, and its
// result is loaded once the output register is free. An insertion at the next
// expected height that releases a run of items first finds the run length by
// testing one slot valid bit per cycle, then the tags leave at one per cycle
// through the single read port of the tag store, so that every result of the
// run carries its release count. A stalled result side holds the release. Slot
// valid bits are flip-flops cleared at reset and on a start_height write, so
// there is no clearing pass. Register 0 (start_height) is at byte 0 and
// register 1 (max_ahead) at byte 4; paddr[1:0] are ignored.
`include "ordered_retire_reorder_window_defines.svh"

module ordered_retire_reorder_window
    import orw_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    orw_in_if.sink      req,
    orw_out_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [HEIGHT_W-1:0] start_height_reg;
    logic [LIMIT_W-1:0]  max_ahead_reg;
    logic                cfg_wr;
    logic                start_wr;
    orw_cmd_t            cmd;
    orw_sts_t            sts;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign start_wr = cfg_wr && (paddr[2] == REG_START_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_height_reg <= '0;
            max_ahead_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_START_HEIGHT: start_height_reg <= pwdata[HEIGHT_W-1:0];
                REG_MAX_AHEAD:    max_ahead_reg    <= pwdata[LIMIT_W-1:0];
                default:          max_ahead_reg    <= max_ahead_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_START_HEIGHT: prdata = 32'(start_height_reg);
            REG_MAX_AHEAD:    prdata = 32'(max_ahead_reg);
            default:          prdata = '0;
        endcase
    end

    orw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    orw_dp #(
        .WINDOW   (WINDOW),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_mode     (req.mode),
        .in_height   (req.in_height),
        .in_tag      (req.in_tag),
        .start_wr    (start_wr),
        .start_value (pwdata[HEIGHT_W-1:0]),
        .max_ahead   (max_ahead_reg),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .status      (rsp.status),
        .rel_count   (rsp.rel_count),
        .has_item    (rsp.has_item),
        .out_height  (rsp.out_height),
        .out_tag     (rsp.out_tag),
        .last        (rsp.last)
    );

    // One item in flight: no transaction right after an accepted one
    `ORW_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "item taken while busy")
    // Only released items carry the ready status
    `ORW_ASSERT_NOW(a_item_status, rsp.valid, rsp.has_item == (rsp.status == ST_READY), "has_item and status disagree")
    // When waiting for an item, a pending result must be the final one
    `ORW_ASSERT_NOW(a_idle_last, req.ready && rsp.valid, rsp.last, "idle with a run unfinished")

endmodule

/* tb/tb_ordered_retire_reorder_window.sv */
// Self-checking testbench for the in-order retire window.
// Needs orw_pkg, orw_in_if/orw_out_if and the ordered_retire_reorder_window top level.
`timescale 1ns / 100ps

module tb_ordered_retire_reorder_window;
    import orw_pkg::*;

    localparam int SLOTS       = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                has_item;
        logic [HEIGHT_W-1:0] height;
        logic [TAG_W-1:0]    tag;
        logic                last;
    } result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // For ROW_CFG rows the height field carries the register value.
    typedef struct packed {
        row_kind_t           kind;
        logic                mode;
        logic [31:0]         height;
        logic [31:0]         tag;
        logic                reg_sel;
        logic                typed;
        logic [STATUS_W-1:0] typed_status;
    } stim_row_t;

    localparam int DIR_ROWS = 28;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    orw_in_if  req_if ();
    orw_out_if rsp_if ();

    ordered_retire_reorder_window uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state
    logic [HEIGHT_W-1:0] next_h;
    logic [LIMIT_W-1:0]  ahead_limit;
    logic                slot_busy [SLOTS];
    logic [TAG_W-1:0]    slot_ref  [SLOTS];

    result_t step_results [$];
    result_t due_results  [$];

    int mismatch_cnt = 0;
    int cyc_cnt = 0;
    int snd_idle_pct;
    int rcv_idle_pct;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, 1'b0, 32'd0,          32'd0,          REG_START_HEIGHT, 1'b1, ST_ACCEPTED},
        '{ROW_ITEM, 1'b0, 32'hFFFF_FFFF,  32'd0,          REG_START_HEIGHT, 1'b1, ST_INVALID},
        '{ROW_ITEM, 1'b1, 32'h8000_0000,  32'hFFFF_FFFF,  REG_START_HEIGHT, 1'b1, ST_INVALID},
        '{ROW_ITEM, 1'b0, 32'd63,         32'd0,          REG_START_HEIGHT, 1'b1, ST_ACCEPTED},
        '{ROW_ITEM, 1'b0, 32'd64,         32'd0,          REG_START_HEIGHT, 1'b1, ST_TOO_FAR},
        '{ROW_ITEM, 1'b1, 32'd64,         32'd1,          REG_START_HEIGHT, 1'b1, ST_TOO_FAR},
        '{ROW_ITEM, 1'b1, 32'h7FFF_FFFF,  32'd2,          REG_START_HEIGHT, 1'b1, ST_TOO_FAR},
        '{ROW_ITEM, 1'b1, 32'd2,          32'hFFFF_FFFF,  REG_START_HEIGHT, 1'b1, ST_QUEUED},
        '{ROW_ITEM, 1'b1, 32'd2,          32'd0,          REG_START_HEIGHT, 1'b1, ST_DUPLICATE},
        '{ROW_ITEM, 1'b1, 32'd1,          32'd0,          REG_START_HEIGHT, 1'b1, ST_QUEUED},
        '{ROW_ITEM, 1'b1, 32'd0,          32'hA5A5_A5A5,  REG_START_HEIGHT, 1'b0, ST_READY},
        '{ROW_ITEM, 1'b0, 32'd2,          32'd0,          REG_START_HEIGHT, 1'b1, ST_STALE},
        '{ROW_ITEM, 1'b1, 32'd1,          32'd0,          REG_START_HEIGHT, 1'b1, ST_STALE},
        '{ROW_ITEM, 1'b1, 32'd66,         32'h5A5A_5A5A,  REG_START_HEIGHT, 1'b1, ST_QUEUED},
        '{ROW_ITEM, 1'b1, 32'd3,          32'h1234_5678,  REG_START_HEIGHT, 1'b0, ST_READY},
        '{ROW_CFG,  1'b0, 32'd1,          32'd0,          REG_MAX_AHEAD,    1'b0, ST_ACCEPTED},
        '{ROW_ITEM, 1'b0, 32'd4,          32'd0,          REG_START_HEIGHT, 1'b1, ST_ACCEPTED},
        '{ROW_ITEM, 1'b0, 32'd5,          32'd0,          REG_START_HEIGHT, 1'b1, ST_TOO_FAR},
        '{ROW_ITEM, 1'b1, 32'd5,          32'hCAFE_0001,  REG_START_HEIGHT, 1'b1, ST_QUEUED},
        '{ROW_CFG,  1'b0, 32'd127,        32'd0,          REG_MAX_AHEAD,    1'b0, ST_ACCEPTED},
        '{ROW_ITEM, 1'b0, 32'd67,         32'd0,          REG_START_HEIGHT, 1'b1, ST_ACCEPTED},
        '{ROW_ITEM, 1'b0, 32'd68,         32'd0,          REG_START_HEIGHT, 1'b1, ST_TOO_FAR},
        '{ROW_CFG,  1'b0, 32'h7FFF_FFFE,  32'd0,          REG_START_HEIGHT, 1'b0, ST_ACCEPTED},
        '{ROW_ITEM, 1'b1, 32'h7FFF_FFFF,  32'h0000_0001,  REG_START_HEIGHT, 1'b1, ST_QUEUED},
        '{ROW_ITEM, 1'b1, 32'h7FFF_FFFE,  32'h8000_0000,  REG_START_HEIGHT, 1'b0, ST_READY},
        '{ROW_ITEM, 1'b1, 32'h7FFF_FFFF,  32'h7FFF_FFFF,  REG_START_HEIGHT, 1'b0, ST_READY},
        '{ROW_ITEM, 1'b0, 32'h7FFF_FFFE,  32'd0,          REG_START_HEIGHT, 1'b1, ST_STALE},
        '{ROW_ITEM, 1'b0, 32'h7FFF_FFFF,  32'd0,          REG_START_HEIGHT, 1'b1, ST_ACCEPTED}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = '{status: rsp_if.status, count: rsp_if.rel_count,
                    has_item: rsp_if.has_item, height: rsp_if.out_height,
                    tag: rsp_if.out_tag, last: rsp_if.last};
            if (due_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result: st=%0d cnt=%0d h=%0h tag=%0h last=%0b",
                             got.status, got.count, got.height, got.tag, got.last);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.status !== want.status || got.count !== want.count ||
                    got.has_item !== want.has_item || got.height !== want.height ||
                    got.tag !== want.tag || got.last !== want.last)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"result mismatch at cycle %0d: want st=%0d cnt=%0d has=%0b",
                                  " h=%0h tag=%0h last=%0b / got st=%0d cnt=%0d has=%0b",
                                  " h=%0h tag=%0h last=%0b"},
                                 cyc_cnt, want.status, want.count, want.has_item,
                                 want.height, want.tag, want.last, got.status, got.count,
                                 got.has_item, got.height, got.tag, got.last);
                end
            end
        end
    end

    function automatic void push_status(input logic [STATUS_W-1:0] st);
        step_results.insert(step_results.size(),
                            result_t'{status: st, count: '0, has_item: 1'b0,
                                      height: '0, tag: '0, last: 1'b1});
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_ref[i]  = '0;
        end
    endfunction

    // Work out the results of one accepted item and advance the window state.
    function automatic void retire_predict(input logic md, input logic [31:0] h,
                                           input logic [31:0] tg);
        logic [31:0] offset;
        int          lim;
        int          cnt;
        int          s;
        step_results.delete();
        if (h[31])
        begin
            push_status(ST_INVALID);
            return;
        end
        if (h[30:0] < next_h)
        begin
            push_status(ST_STALE);
            return;
        end
        offset = h - {1'b0, next_h};
        if (!md)
        begin
            lim = (ahead_limit == 0 || ahead_limit > SLOTS) ? SLOTS : int'(ahead_limit);
            push_status((offset >= lim) ? ST_TOO_FAR : ST_ACCEPTED);
            return;
        end
        if (offset >= SLOTS)
        begin
            push_status(ST_TOO_FAR);
            return;
        end
        s = int'(h[5:0]);
        if (slot_busy[s])
        begin
            push_status(ST_DUPLICATE);
            return;
        end
        slot_busy[s] = 1'b1;
        slot_ref[s]  = tg;
        cnt = 0;
        while (cnt < SLOTS && slot_busy[next_h[5:0]])
        begin
            s = int'(next_h[5:0]);
            step_results.insert(step_results.size(),
                                result_t'{status: ST_READY, count: '0, has_item: 1'b1,
                                          height: next_h, tag: slot_ref[s], last: 1'b0});
            slot_busy[s] = 1'b0;
            cnt++;
            // hold at the top height once it has retired
            if (next_h == HEIGHT_MAX)
                break;
            next_h = next_h + 1'b1;
        end
        if (cnt == 0)
        begin
            push_status(ST_QUEUED);
            return;
        end
        foreach (step_results[k])
        begin
            step_results[k].count = COUNT_W'(cnt);
            step_results[k].last  = (k == cnt - 1);
        end
    endfunction

    task automatic send_item(input logic md, input logic [31:0] h, input logic [31:0] tg,
                             input logic typed, input logic [STATUS_W-1:0] typed_st);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.mode      <= md;
        req_if.in_height <= h;
        req_if.in_tag    <= tg;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        retire_predict(md, h, tg);
        if (typed)
            due_results.insert(due_results.size(),
                               result_t'{status: typed_st, count: '0, has_item: 1'b0,
                                         height: '0, tag: '0, last: 1'b1});
        else
            foreach (step_results[k])
                due_results.insert(due_results.size(), step_results[k]);
        @(negedge clk);
    endtask

    // Drain the window, then write one register over APB.
    task automatic write_reg_idle(input logic reg_sel, input logic [31:0] val);
        req_if.valid <= 1'b0;
        wait (due_results.size() == 0);
        repeat (4) @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == REG_START_HEIGHT)
        begin
            next_h = val[HEIGHT_W-1:0];
            clear_window();
        end
        else
            ahead_limit = val[LIMIT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_noise();
        logic [31:0] h;
        case ($urandom_range(0, 5))
            0: send_item(1'b0, {1'b0, next_h} + $urandom_range(0, 80), $urandom(),
                         1'b0, ST_ACCEPTED);
            1:
            begin
                if (next_h != 0)
                    h = $urandom_range(0, int'(next_h) - 1);
                else
                    h = $urandom() | 32'h8000_0000;
                send_item(1'($urandom_range(0, 1)), h, $urandom(), 1'b0, ST_ACCEPTED);
            end
            2: send_item(1'($urandom_range(0, 1)), $urandom() | 32'h8000_0000, $urandom(),
                         1'b0, ST_ACCEPTED);
            3: send_item(1'b1, {1'b0, next_h} + $urandom_range(64, 300), $urandom(),
                         1'b0, ST_ACCEPTED);
            4: send_item(1'b1, {1'b0, next_h} + $urandom_range(0, 63), $urandom(),
                         1'b0, ST_ACCEPTED);
            default: send_item(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                               1'b0, ST_ACCEPTED);
        endcase
    endtask

    // Shuffled runs of consecutive heights, with noise mixed in.
    task automatic run_segment(input int n_items);
        int                  sent;
        int                  run_len;
        int                  order [SLOTS];
        int                  j;
        int                  t;
        logic [HEIGHT_W-1:0] base;
        sent = 0;
        while (sent < n_items)
        begin
            run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(16, SLOTS)
                                                   : $urandom_range(1, 8);
            for (int i = 0; i < run_len; i++)
                order[i] = i;
            for (int i = run_len - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                t = order[i];
                order[i] = order[j];
                order[j] = t;
            end
            base = next_h;
            for (int i = 0; i < run_len && sent < n_items; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_noise();
                    sent++;
                end
                send_item(1'b1, {1'b0, base} + order[i], $urandom(), 1'b0, ST_ACCEPTED);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.mode      = 1'b0;
        req_if.in_height = '0;
        req_if.in_tag    = '0;
        snd_idle_pct     = 20;
        rcv_idle_pct     = 79;
        next_h           = '0;
        ahead_limit      = '0;
        clear_window();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg_idle(dir_rows[r].reg_sel, dir_rows[r].height);
            else
                send_item(dir_rows[r].mode, dir_rows[r].height, dir_rows[r].tag,
                          dir_rows[r].typed, dir_rows[r].typed_status);
        end

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:
                begin
                    write_reg_idle(REG_START_HEIGHT, 32'd0);
                    write_reg_idle(REG_MAX_AHEAD, 32'd0);
                end
                1:
                begin
                    // full pwdata width; the upper bit is dropped by the register
                    write_reg_idle(REG_START_HEIGHT, $urandom());
                    write_reg_idle(REG_MAX_AHEAD, 32'd64);
                end
                2:
                begin
                    snd_idle_pct = 79;
                    rcv_idle_pct = 20;
                    write_reg_idle(REG_START_HEIGHT, 32'h7FFF_FFFF - 32'd200);
                    write_reg_idle(REG_MAX_AHEAD, 32'd1);
                end
                3:
                begin
                    write_reg_idle(REG_START_HEIGHT, $urandom() & 32'h7FFF_FFFF);
                    write_reg_idle(REG_MAX_AHEAD, $urandom_range(0, 127));
                end
                4:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    write_reg_idle(REG_START_HEIGHT, $urandom_range(0, 1000));
                    write_reg_idle(REG_MAX_AHEAD, 32'd127);
                end
                default:
                begin
                    write_reg_idle(REG_START_HEIGHT, 32'd0);
                    write_reg_idle(REG_MAX_AHEAD, $urandom_range(2, 63));
                end
            endcase
            run_segment(58);
        end

        req_if.valid <= 1'b0;
        wait (due_results.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
